// File: design/plm_pkg.sv
package plm_pkg;

    // Default sizing of the block.
    localparam int MAX_LISTS_DEF = 8;
    localparam int ID_BITS_DEF   = 32;

    // Widths of the transaction fields and of the configuration registers.
    localparam int ID_W        = 32;
    localparam int INDEX_W     = 3;
    localparam int INDEX_REACH = 8;
    localparam int COUNT_W     = 4;
    localparam int KIND_W      = 2;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_SEL_W = 1;

    localparam logic [REG_SEL_W-1:0] REG_MERGE_MODE = 1'b0;
    localparam logic [REG_SEL_W-1:0] REG_LIST_COUNT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ID      = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_JUMP    = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic in_use;
        logic wr_en;
        logic wr_end;
        logic out_free;
        logic tok_kill;
    } cell_ctrl_t;

    // Request a cell raises while it holds the token.
    typedef struct packed {
        logic valid;
        logic jump;
    } cell_req_t;

    // Flags that travel with the running minimum and maximum.
    typedef struct packed {
        logic any_live;
        logic any_end;
    } scan_flags_t;

endpackage

// File: design/plm_cell.sv
module plm_cell #(
    parameter int MAX_LISTS = plm_pkg::MAX_LISTS_DEF,
    parameter int ID_BITS   = plm_pkg::ID_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  plm_pkg::cell_ctrl_t              ctrl,
    input  logic [ID_BITS-1:0]               wr_head,
    input  plm_pkg::scan_flags_t             flags_in,
    input  logic [ID_BITS-1:0]               lo_in,
    input  logic [ID_BITS-1:0]               hi_in,
    input  logic [$clog2(MAX_LISTS+1)-1:0]   cnt_in,
    output plm_pkg::scan_flags_t             flags_out,
    output logic [ID_BITS-1:0]               lo_out,
    output logic [ID_BITS-1:0]               hi_out,
    output logic [$clog2(MAX_LISTS+1)-1:0]   cnt_out,
    input  logic [ID_BITS-1:0]               rnd_lo,
    input  logic [ID_BITS-1:0]               rnd_hi,
    input  logic                             tok_in,
    output logic                             tok_out,
    output plm_pkg::cell_req_t               req,
    output logic                             awaiting
);
    import plm_pkg::*;

    localparam int CNT_W = $clog2(MAX_LISTS + 1);

    logic [ID_BITS-1:0] head_reg;
    logic               ended_reg;
    logic               await_reg;
    logic               await_next;
    logic               tok_reg;
    logic               tok_next;
    logic               live;
    logic               need;

    scan_flags_t        flags_reg;
    scan_flags_t        flags_next;
    logic [ID_BITS-1:0] lo_reg;
    logic [ID_BITS-1:0] lo_next;
    logic [ID_BITS-1:0] hi_reg;
    logic [ID_BITS-1:0] hi_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign live = ctrl.in_use & ~ended_reg;
    assign need = live & (head_reg == rnd_lo);

    assign req.valid = tok_reg & need;
    assign req.jump  = head_reg != rnd_hi;
    assign tok_out   = tok_reg & (~need | ctrl.out_free);
    assign awaiting  = await_reg;

    always_comb begin
        tok_next = ctrl.tok_kill ? 1'b0 : (tok_in | (tok_reg & need & ~ctrl.out_free));
        if (ctrl.wr_en) begin
            await_next = 1'b0;
        end else if (req.valid && ctrl.out_free) begin
            await_next = 1'b1;
        end else begin
            await_next = await_reg;
        end
    end

    // Fold this list into the running minimum, its multiplicity and the maximum.
    always_comb begin
        flags_next.any_end  = flags_in.any_end | (ctrl.in_use & ended_reg);
        flags_next.any_live = flags_in.any_live | live;
        lo_next  = lo_in;
        hi_next  = hi_in;
        cnt_next = cnt_in;
        if (live) begin
            if (!flags_in.any_live || head_reg < lo_in) begin
                lo_next  = head_reg;
                cnt_next = CNT_W'(1);
            end else if (head_reg == lo_in) begin
                cnt_next = cnt_in + CNT_W'(1);
            end
            if (!flags_in.any_live || head_reg > hi_in) begin
                hi_next = head_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ended_reg <= 1'b0;
            await_reg <= 1'b1;
            tok_reg   <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                ended_reg <= ctrl.wr_end;
            end
            await_reg <= await_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && !ctrl.wr_end) begin
            head_reg <= wr_head;
        end
        flags_reg <= flags_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        cnt_reg   <= cnt_next;
    end

    assign flags_out = flags_reg;
    assign lo_out    = lo_reg;
    assign hi_out    = hi_reg;
    assign cnt_out   = cnt_reg;

endmodule

// File: design/posting_list_merge.sv
// K-way merge of sorted posting lists, as union (merge_mode 0) or intersection (merge_mode 1),
// over list_count lists (0 is taken as 1, larger values saturate at the number of cells or 8).
// Every input transaction reports the new head ID of one list, or that the list has ended;
// reports from lists that owe none, from lists beyond the count, or after the merge is over
// are taken and dropped. Once every list in use has reported, the block runs a round: a
// merged-ID transaction (union, or intersection when all heads agree), then one advance or
// jump transaction per list that must move, each addressing the list that owes the next
// report; m_last marks the final transaction of the round. When the merge is over a single
// done transaction is sent and all further input is dropped until reset. Each list lives in
// one cell of a chain of MAX_LISTS cells; the running minimum, its multiplicity and the
// maximum pass from cell to cell one step per clock, and a token then walks the chain to
// collect the requests. A report that does not complete a round is recorded and checked,
// and the block returns to idle. A report that completes one is followed by the scan
// through the chain, the merged ID or done transaction, and the token walk, which ends at
// the last requesting cell; m_ready held low while a transaction waits stalls the round.
// The output register lets a finished transaction wait while the chain keeps working.
// Configuration is written through an APB-style port with merge_mode at address 0 and
// list_count at address 4.
module posting_list_merge #(
    parameter int MAX_LISTS = plm_pkg::MAX_LISTS_DEF,
    parameter int ID_BITS   = plm_pkg::ID_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plm_pkg::PADDR_W-1:0]   paddr,
    input  logic [plm_pkg::PDATA_W-1:0]   pwdata,
    output logic [plm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // Report channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [plm_pkg::INDEX_W-1:0]   s_list_index,
    input  logic [plm_pkg::ID_W-1:0]      s_head_id,
    input  logic                          s_at_end,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [plm_pkg::KIND_W-1:0]    m_kind,
    output logic [plm_pkg::INDEX_W-1:0]   m_target_list,
    output logic [plm_pkg::ID_W-1:0]      m_id_value,
    output logic                          m_last
);
    import plm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_LISTS + 1);
    localparam int SCAN_W = $clog2(MAX_LISTS);
    localparam int NLIM   = (MAX_LISTS < INDEX_REACH) ? MAX_LISTS : INDEX_REACH;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_HEAD  = 6'b001000,
        ST_REQ   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;

    // Configuration registers.
    logic                 mode_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   n_eff;
    logic                 apb_wr;
    logic [REG_SEL_W-1:0] reg_sel;

    // Round state.
    logic [SCAN_W-1:0]    scan_cnt_reg;
    logic [SCAN_W-1:0]    scan_cnt_next;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic                 latch;
    scan_flags_t          rnd_flags_reg;
    logic [ID_BITS-1:0]   rnd_lo_reg;
    logic [ID_BITS-1:0]   rnd_hi_reg;
    logic                 finish;

    // Output register.
    logic                 m_valid_reg;
    logic                 m_valid_next;
    kind_t                kind_reg;
    logic [INDEX_W-1:0]   target_reg;
    logic [ID_W-1:0]      id_reg;
    logic                 last_reg;
    logic                 out_free;
    logic                 load;
    kind_t                ld_kind;
    logic [INDEX_W-1:0]   ld_target;
    logic [ID_W-1:0]      ld_id;
    logic                 ld_last;

    // Input side.
    logic                 s_fire;
    logic                 rep_ok;
    logic                 rec;
    logic [ID_BITS-1:0]   head_ext;

    // Cell chain.
    logic [MAX_LISTS-1:0]   in_use;
    logic [MAX_LISTS-1:0]   wr_sel;
    logic [MAX_LISTS-1:0]   await_vec;
    logic [INDEX_REACH-1:0] await8;
    logic                   any_await;
    cell_ctrl_t             ctrl      [MAX_LISTS];
    cell_req_t              req       [MAX_LISTS];
    logic [MAX_LISTS-1:0]   req_valid;
    logic [MAX_LISTS:0]     tok_c;
    scan_flags_t            flags_c   [MAX_LISTS+1];
    logic [ID_BITS-1:0]     lo_c      [MAX_LISTS+1];
    logic [ID_BITS-1:0]     hi_c      [MAX_LISTS+1];
    logic [CNT_W-1:0]       cnt_c     [MAX_LISTS+1];
    logic                   inject;
    logic                   tok_kill;
    logic                   req_any;
    logic                   req_jump;
    logic [INDEX_W-1:0]     req_target;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access cycle; reads
    // return the stored value.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite & pready;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_comb begin
        case (reg_sel)
            REG_MERGE_MODE: prdata = PDATA_W'(mode_reg);
            REG_LIST_COUNT: prdata = PDATA_W'(count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            count_reg <= COUNT_W'(1);
        end else if (apb_wr) begin
            case (reg_sel)
                REG_MERGE_MODE: mode_reg  <= pwdata[0];
                REG_LIST_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // A count of zero acts as one list; large counts saturate at the cells
    // that a report index can reach.
    always_comb begin
        if (count_reg == '0) begin
            n_eff = COUNT_W'(1);
        end else if (count_reg > COUNT_W'(NLIM)) begin
            n_eff = COUNT_W'(NLIM);
        end else begin
            n_eff = count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input side. Reports are taken while idle and after the merge is
    // over; only a report from a list in use that owes one is recorded.
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE) || (state_reg == ST_DONE);
    assign s_fire   = s_valid & s_ready;
    assign rep_ok   = ({1'b0, s_list_index} < n_eff) && await8[s_list_index];
    assign rec      = s_fire && (state_reg == ST_IDLE) && rep_ok;
    assign head_ext = ID_BITS'(s_head_id);

    assign any_await = |(await_vec & in_use);

    // ------------------------------------------------------------------
    // Chain of list cells. The head of the chain sees an empty scan.
    // ------------------------------------------------------------------
    assign flags_c[0] = '{any_live: 1'b0, any_end: 1'b0};
    assign lo_c[0]    = '1;
    assign hi_c[0]    = '0;
    assign cnt_c[0]   = '0;
    assign tok_c[0]   = inject;

    genvar gi;
    generate
        for (gi = 0; gi < INDEX_REACH; gi++) begin : g_await
            if (gi < MAX_LISTS) begin : g_cell
                assign await8[gi] = await_vec[gi];
            end else begin : g_none
                assign await8[gi] = 1'b0;
            end
        end

        for (gi = 0; gi < MAX_LISTS; gi++) begin : g_chain
            if (gi < INDEX_REACH) begin : g_reach
                assign in_use[gi] = n_eff > COUNT_W'(gi);
                assign wr_sel[gi] = s_list_index == INDEX_W'(gi);
            end else begin : g_beyond
                assign in_use[gi] = 1'b0;
                assign wr_sel[gi] = 1'b0;
            end

            assign ctrl[gi] = '{in_use:   in_use[gi],
                                wr_en:    rec & wr_sel[gi],
                                wr_end:   s_at_end,
                                out_free: out_free,
                                tok_kill: tok_kill};
            assign req_valid[gi] = req[gi].valid;

            plm_cell #(
                .MAX_LISTS (MAX_LISTS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl[gi]),
                .wr_head   (head_ext),
                .flags_in  (flags_c[gi]),
                .lo_in     (lo_c[gi]),
                .hi_in     (hi_c[gi]),
                .cnt_in    (cnt_c[gi]),
                .flags_out (flags_c[gi+1]),
                .lo_out    (lo_c[gi+1]),
                .hi_out    (hi_c[gi+1]),
                .cnt_out   (cnt_c[gi+1]),
                .rnd_lo    (rnd_lo_reg),
                .rnd_hi    (rnd_hi_reg),
                .tok_in    (tok_c[gi]),
                .tok_out   (tok_c[gi+1]),
                .req       (req[gi]),
                .awaiting  (await_vec[gi])
            );
        end
    endgenerate

    // At most one cell holds the token, so the request is a plain OR.
    always_comb begin
        req_any    = 1'b0;
        req_jump   = 1'b0;
        req_target = '0;
        for (int i = 0; i < MAX_LISTS; i++) begin
            if (req[i].valid) begin
                req_any    = 1'b1;
                req_jump   = req[i].jump;
                req_target = req_target | INDEX_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Round sequencer.
    // ------------------------------------------------------------------
    assign out_free = ~m_valid_reg | m_ready;
    assign finish   = mode_reg ? rnd_flags_reg.any_end : ~rnd_flags_reg.any_live;

    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        rem_next      = rem_reg;
        latch         = 1'b0;
        load          = 1'b0;
        ld_kind       = KIND_ID;
        ld_target     = '0;
        ld_id         = '0;
        ld_last       = 1'b0;
        inject        = 1'b0;
        tok_kill      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (rec) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!any_await) begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // The chain settles one cell per cycle; the tail is latched when the
                // scan counter reaches MAX_LISTS - 1.
                if (scan_cnt_reg == SCAN_W'(MAX_LISTS - 1)) begin
                    latch      = 1'b1;
                    rem_next   = cnt_c[MAX_LISTS];
                    state_next = ST_HEAD;
                end else begin
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
            end
            ST_HEAD: begin
                if (finish) begin
                    if (out_free) begin
                        load       = 1'b1;
                        ld_kind    = KIND_DONE;
                        ld_last    = 1'b1;
                        state_next = ST_DONE;
                    end
                end else if (!mode_reg || rnd_lo_reg == rnd_hi_reg) begin
                    if (out_free) begin
                        load       = 1'b1;
                        ld_kind    = KIND_ID;
                        ld_id      = ID_W'(rnd_lo_reg);
                        inject     = 1'b1;
                        state_next = ST_REQ;
                    end
                end else begin
                    inject     = 1'b1;
                    state_next = ST_REQ;
                end
            end
            ST_REQ: begin
                if (req_any && out_free) begin
                    load      = 1'b1;
                    ld_target = req_target;
                    if (mode_reg && req_jump) begin
                        ld_kind = KIND_JUMP;
                        ld_id   = ID_W'(rnd_hi_reg);
                    end else begin
                        ld_kind = KIND_ADVANCE;
                    end
                    ld_last  = rem_reg == CNT_W'(1);
                    rem_next = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        tok_kill   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                state_next = ST_DONE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            rem_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            rem_reg      <= rem_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (latch) begin
            rnd_flags_reg <= flags_c[MAX_LISTS];
            rnd_lo_reg    <= lo_c[MAX_LISTS];
            rnd_hi_reg    <= hi_c[MAX_LISTS];
        end
        if (load) begin
            kind_reg   <= ld_kind;
            target_reg <= ld_target;
            id_reg     <= ld_id;
            last_reg   <= ld_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_target_list = target_reg;
    assign m_id_value    = id_reg;
    assign m_last        = last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // At most one cell raises a request at a time.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(req_valid))
        else $error("more than one cell requests at once");

    // Once the merge is over the block stays finished until reset.
    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |=> state_reg == ST_DONE)
        else $error("left the finished state without reset");

    // A done transaction always closes its round.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_DONE) |-> m_last)
        else $error("done transaction without last");

    // A round only starts when no list in use owes a report.
    a_round_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && state_next == ST_SCAN) |-> !any_await)
        else $error("round started while a report is owed");

endmodule
